[sv/pilt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pilt_pkg;
    localparam int TICKS_PER_SEC = 8;
    localparam int TPS_W = 5;
    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [7:0] LAST_SEQ_MAX = 8'h71;
    localparam logic [31:0] NEXT_MAX   = 32'(8 * 60 * TICKS_PER_SEC);
    localparam logic [31:0] SAME_MAX   = 32'(1 * 60 * TICKS_PER_SEC);
    localparam logic [31:0] FIRST_LO   = 32'(3 * 60 * TICKS_PER_SEC);
    localparam logic [31:0] FIRST_HI   = 32'(7 * 60 * TICKS_PER_SEC);
    localparam logic [31:0] REP_LO     = 32'(8 * TICKS_PER_SEC);
    localparam logic [31:0] REP_HI     = 32'(25 * TICKS_PER_SEC);
    localparam logic [31:0] CHK_REP_LO = 32'(5 * TICKS_PER_SEC);
    localparam logic [31:0] SUM_HI     = 32'((8 * 5 * 60 + 3) * TICKS_PER_SEC);
    localparam logic [31:0] SUM_LO     = 32'((8 * 5 * 60 - 3) * TICKS_PER_SEC);
    localparam logic [31:0] SUM_EXACT  = 32'(8 * 5 * 60 * TICKS_PER_SEC);
    localparam logic [15:0] PERIOD     = 16'(5 * 60 * TICKS_PER_SEC);
    localparam logic [15:0] MAX_INIT   = 16'(0 - 20 * 60 * TICKS_PER_SEC);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_RD1, ST_RD2, ST_LRN, ST_RD3, ST_LRN2,
        ST_RND_RD, ST_RND_WR, ST_CHK, ST_OFF, ST_ADJ, ST_QRD, ST_QOUT
    } state_t;
endpackage
`default_nettype wire

[sv/packet_interval_learning_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata (low bit up)                                      | tuser
// s_axis  | in  | opcode[1:0] new_seq[9:2] last_seq[17:10]                 | -
//         |     | elapsed_ticks[33:18] query_seq[41:34], pad to 48          |
// m_axis  | out | entry_ticks[15:0] slot_adjust[31:16] table_valid[32]      | -
//         |     | table_frozen[33], pad to 40                               |
// One transaction at a time; a query, opcode 3 or ignored observe goes through ST_QRD and ST_QOUT
// into the output register. Clear: a zeroing sweep of both stores, then the query read.
// Observe: learn read-modify-writes on the interval RAM, a 16-entry round/filter pass, then, if the
// table checks valid, an 8-step prefix pass and an 8-entry offset write; last the query read.
// Reset zeroes both stores by a sweep of all 16 interval entries; s_axis_tready stays low meanwhile.
// A result waits in the output register; a newer one holds in ST_QOUT until m_axis_tready.
module packet_interval_learning_table_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // opcode, new_seq, last_seq, elapsed_ticks, query_seq
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata   // entry_ticks, slot_adjust, valid, frozen
);
    import pilt_pkg::*;

    state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [7:0]  ns_reg, ns_next, ls_reg, ls_next, q_reg, q_next;
    logic [15:0] tk_reg, tk_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rep_reg, rep_next, acc_reg, acc_next, max_reg, max_next;
    logic [31:0] sum_reg, sum_next;
    logic        rep_ok_reg, rep_ok_next;
    logic        frz_reg, frz_next, vld_reg, vld_next;
    logic        ov_reg, ov_next;
    logic [33:0] od_reg, od_next;
    logic [15:0] d_reg [8];
    logic [15:0] d_wr;
    logic [2:0]  d_idx;
    logic        d_we;

    // interval RAM
    logic        iwe;
    logic [3:0]  iwa, ira;
    logic [15:0] iwd, ird;
    // adjust RAM
    logic        awe;
    logic [2:0]  awa, ara;
    logic [15:0] awd, ard;

    pilt_ram #(.WIDTH(16), .DEPTH(16)) u_int (
        .clk(clk), .we(iwe), .waddr(iwa), .wdata(iwd), .raddr(ira), .rdata(ird));
    pilt_ram #(.WIDTH(16), .DEPTH(8)) u_adj (
        .clk(clk), .we(awe), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(ard));

    logic [3:0]  ls_s, ns_s;
    logic        lsub, nsub, is_next, is_same;
    logic [15:0] lrn_val, lrn_res, rnd_res;
    logic [TPS_W-1:0] rem;
    logic [3:0]  e_first, e_rep;

    assign ls_s = ls_reg[7:4];
    assign ns_s = ns_reg[7:4];
    assign lsub = ls_reg[0];
    assign nsub = ns_reg[0];
    assign is_next = (ns_s == {1'b0, ls_s[2:0] + 3'd1}) && (ls_s < 4'd8)
                     && (32'(tk_reg) < NEXT_MAX);
    assign is_same = (ns_s == ls_s) && (32'(tk_reg) < SAME_MAX);
    assign e_first = {ls_s[2:0], 1'b0};
    assign e_rep   = {ns_s[2:0], 1'b1};

    // learn: empty takes directly, else average
    function automatic logic [15:0] learn_f(input logic [15:0] old, input logic [15:0] v);
        logic [15:0] s;
        s = old + v;
        return (old == 16'd0) ? v : {1'b0, s[15:1]};
    endfunction

    assign rem = TPS_W'(ird % 16'(TICKS_PER_SEC));

    always_comb
    begin
        logic [15:0] r;
        if (32'(rem) > 32'(TICKS_PER_SEC / 2))
            r = ird + 16'(TICKS_PER_SEC) - 16'(rem);
        else
            r = ird - 16'(rem);
        if (cnt_reg[0] == 1'b0)
            rnd_res = ((32'(r) < FIRST_LO) || (32'(r) > FIRST_HI)) ? 16'd0 : r;
        else
            rnd_res = ((32'(r) < REP_LO) || (32'(r) > REP_HI)) ? 16'd0 : r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            op_reg    <= OP_OBSERVE;
            cnt_reg   <= '0;
            frz_reg   <= 1'b0;
            vld_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            frz_reg   <= frz_next;
            vld_reg   <= vld_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg <= ns_next; ls_reg <= ls_next; q_reg <= q_next;
        tk_reg <= tk_next; rep_reg <= rep_next; acc_reg <= acc_next;
        max_reg <= max_next; sum_reg <= sum_next; rep_ok_reg <= rep_ok_next;
        od_reg <= od_next;
        if (d_we)
        begin
            d_reg[d_idx] <= d_wr;
        end
    end

    always_comb
    begin
        logic [15:0] pa;
        state_next = state_reg; cnt_next = cnt_reg;
        op_next = op_reg; ns_next = ns_reg; ls_next = ls_reg; q_next = q_reg;
        tk_next = tk_reg; rep_next = rep_reg; acc_next = acc_reg;
        max_next = max_reg; sum_next = sum_reg; rep_ok_next = rep_ok_reg;
        frz_next = frz_reg; vld_next = vld_reg; ov_next = ov_reg; od_next = od_reg;
        iwe = 1'b0; iwa = cnt_reg[3:0]; iwd = '0; ira = cnt_reg[3:0];
        awe = 1'b0; awa = cnt_reg[2:0]; awd = '0; ara = q_reg[6:4];
        d_we = 1'b0; d_idx = cnt_reg[2:0]; d_wr = '0;
        lrn_val = '0; lrn_res = '0; pa = '0;
        s_axis_tready = 1'b0;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // a waiting result is held in od_reg; accept the next transaction anyway
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tdata[1:0];
                    ns_next = s_axis_tdata[9:2];
                    ls_next = s_axis_tdata[17:10];
                    tk_next = s_axis_tdata[33:18];
                    q_next  = s_axis_tdata[41:34];
                    cnt_next = '0;
                    if (s_axis_tdata[1:0] == OP_CLEAR)
                        state_next = ST_CLR;
                    else if (s_axis_tdata[1:0] == OP_OBSERVE && !frz_reg
                             && s_axis_tdata[17:10] <= LAST_SEQ_MAX)
                        state_next = ST_RD1;
                    else
                        state_next = ST_QRD;
                end
            end
            ST_CLR:
            begin
                iwe = 1'b1; iwa = cnt_reg[3:0];
                awe = 1'b1; awa = cnt_reg[2:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = (op_reg == OP_CLEAR) ? ST_QRD : ST_IDLE;
            end
            ST_RD1:
            begin
                // fetch repeat entry of new slot
                ira = e_rep;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                rep_next = ird;
                if (is_next && !nsub)
                begin
                    ira = e_first; state_next = ST_LRN;
                end
                else if (is_next && !lsub)
                begin
                    ira = e_first; state_next = ST_LRN;
                end
                else if (!is_next && is_same)
                begin
                    ira = {ls_s[2:0], 1'b1}; state_next = ST_LRN;
                end
                else
                begin
                    cnt_next = '0; state_next = ST_RND_RD;
                end
            end
            ST_LRN:
            begin
                cnt_next = '0;
                state_next = ST_RND_RD;
                if (is_next && !nsub)
                begin
                    iwe = 1'b1; iwa = e_first; iwd = learn_f(ird, tk_reg);
                end
                else if (is_next)
                begin
                    lrn_res = (rep_reg != 16'd0) ? learn_f(ird, tk_reg - rep_reg) : ird;
                    iwe = 1'b1; iwa = e_first; iwd = lrn_res;
                    acc_next = lrn_res;
                    ira = e_rep;
                    state_next = ST_RD3;
                end
                else
                begin
                    iwe = 1'b1; iwa = {ls_s[2:0], 1'b1}; iwd = learn_f(ird, tk_reg);
                end
            end
            ST_RD3:
            begin
                state_next = ST_LRN2;
            end
            ST_LRN2:
            begin
                lrn_val = tk_reg - acc_reg;
                if (acc_reg != 16'd0)
                begin
                    iwe = 1'b1; iwa = e_rep; iwd = learn_f(rep_reg, lrn_val);
                end
                cnt_next = '0;
                state_next = ST_RND_RD;
            end
            ST_RND_RD:
            begin
                ira = cnt_reg[3:0];
                sum_next = '0; rep_ok_next = 1'b1;
                state_next = ST_RND_WR;
            end
            ST_RND_WR:
            begin
                // round and filter this entry, accumulate it (first) or range-check it (repeat); read the next
                iwe = 1'b1; iwa = cnt_reg[3:0]; iwd = rnd_res;
                if (cnt_reg[0] == 1'b0)
                begin
                    sum_next = sum_reg + 32'(rnd_res);
                    d_we = 1'b1; d_idx = cnt_reg[3:1]; d_wr = rnd_res;
                end
                else if (32'(rnd_res) < CHK_REP_LO || 32'(rnd_res) > REP_HI)
                    rep_ok_next = 1'b0;
                ira = cnt_reg[3:0] + 4'd1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cnt_next = '0; acc_next = '0; max_next = MAX_INIT;
                if (sum_reg > SUM_HI || sum_reg < SUM_LO || !rep_ok_reg)
                begin
                    vld_next = 1'b0; state_next = ST_QRD;
                end
                else
                begin
                    vld_next = 1'b1;
                    if (sum_reg == SUM_EXACT)
                        frz_next = 1'b1;
                    state_next = ST_OFF;
                end
            end
            ST_OFF:
            begin
                // d[i] = period*(i+1) - prefix; d_reg holds first entries on entry
                pa = acc_reg + d_reg[cnt_reg[2:0]];
                acc_next = pa;
                d_we = 1'b1; d_idx = cnt_reg[2:0];
                d_wr = 16'(PERIOD * (cnt_reg[2:0] + 16'd1)) - pa;
                if ($signed(d_wr) > $signed(max_reg))
                    max_next = d_wr;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    cnt_next = '0; state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                awe = 1'b1; awa = cnt_reg[2:0];
                awd = max_reg - d_reg[cnt_reg[2:0] - 3'd1];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                    state_next = ST_QRD;
            end
            ST_QRD:
            begin
                ira = {q_reg[6:4], q_reg[0]};
                ara = q_reg[6:4];
                state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {frz_reg, vld_reg | frz_reg, ard, ird};
                    state_next = ST_IDLE;
                end
                ira = {q_reg[6:4], q_reg[0]};
                // hold read addresses so data stays stable while stalled
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, od_reg};
endmodule
`default_nettype wire

[sv/pilt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pilt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[tb/packet_interval_learning_table_top_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module packet_interval_learning_table_top_tb;
    import pilt_pkg::*;

    localparam int TPS = TICKS_PER_SEC;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // opcode, new_seq, last_seq, elapsed_ticks, query_seq
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // entry_ticks, slot_adjust, table_valid, table_frozen

    packet_interval_learning_table_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Highest field first so the layout matches m_axis_tdata[33:0]
    typedef struct packed {
        logic        table_frozen;
        logic        table_valid;
        logic [15:0] slot_adjust;
        logic [15:0] entry_ticks;
    } readback_t;

    // One directed row: command fields plus an optional typed-in answer
    typedef struct {
        logic [1:0]  opcode;
        logic [7:0]  new_seq;
        logic [7:0]  last_seq;
        logic [15:0] ticks;
        logic [7:0]  query_seq;
        bit          has_fixed;
        readback_t   fixed;
    } row_t;

    // Shadow copy of the learned table
    logic [15:0] shadow_interval [16];
    logic [15:0] shadow_adjust [8];
    logic        shadow_frozen;
    logic        shadow_valid;

    readback_t   pending_readbacks [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Safety net: end the run if the handshakes hang
    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic void shadow_learn_wrap(int idx, logic [15:0] v);
        logic [15:0] s;
        s = shadow_interval[idx] + v;  // wraps at 16 bits before the halving
        if (shadow_interval[idx] == 16'd0)
            shadow_interval[idx] = v;
        else
            shadow_interval[idx] = s >> 1;
    endfunction

    // Round every entry to whole seconds, then zero out-of-range entries
    function automatic void shadow_round_filter();
        int r;
        for (int i = 0; i < 16; i++)
        begin
            r = shadow_interval[i] % TPS;
            if (r > TPS / 2)
                shadow_interval[i] = shadow_interval[i] + 16'(TPS - r);
            else
                shadow_interval[i] = shadow_interval[i] - 16'(r);
        end
        for (int i = 0; i < 8; i++)
        begin
            if (shadow_interval[2*i] < 180*TPS || shadow_interval[2*i] > 420*TPS)
                shadow_interval[2*i] = 16'd0;
            if (shadow_interval[2*i+1] < 8*TPS || shadow_interval[2*i+1] > 25*TPS)
                shadow_interval[2*i+1] = 16'd0;
        end
    endfunction

    function automatic bit shadow_check();
        int sum;
        sum = 0;
        shadow_valid = 1'b0;
        for (int i = 0; i < 8; i++) sum += shadow_interval[2*i];
        if (sum > 2403*TPS || sum < 2397*TPS) return 0;
        for (int i = 0; i < 8; i++)
            if (shadow_interval[2*i+1] < 5*TPS || shadow_interval[2*i+1] > 25*TPS)
                return 0;
        if (sum == 2400*TPS) shadow_frozen = 1'b1;
        shadow_valid = 1'b1;
        return 1;
    endfunction

    function automatic void shadow_offsets();
        logic [15:0] d [8];
        logic [15:0] accum;
        logic [15:0] top;
        accum = 16'd0;
        top = 16'(0 - 1200*TPS);
        for (int i = 0; i < 8; i++)
        begin
            accum = accum + shadow_interval[2*i];
            d[i] = 16'(300*TPS*(i+1)) - accum;
            if ($signed(d[i]) > $signed(top)) top = d[i];
        end
        for (int i = 0; i < 8; i++)
            shadow_adjust[i] = top - d[(i+7) % 8];
    endfunction

    function automatic void shadow_observe(logic [7:0] nb, logic [7:0] lb, logic [15:0] t);
        int ls, lsub, ns, nsub;
        logic [15:0] rep;
        if (shadow_frozen || lb > LAST_SEQ_MAX) return;
        ls = lb[7:4]; lsub = lb[0];
        ns = nb[7:4]; nsub = nb[0];
        if (ns == ((ls + 1) % 8) && ls < 8 && t < 480*TPS)
        begin
            if (nsub == 0)
                shadow_learn_wrap(ls*2, t);
            else if (lsub == 0)
            begin
                rep = shadow_interval[(ns*2+1) % 16];
                if (rep != 16'd0) shadow_learn_wrap(ls*2, t - rep);
                if (shadow_interval[ls*2] != 16'd0)
                    shadow_learn_wrap((ns*2+1) % 16, t - shadow_interval[ls*2]);
            end
        end
        else if (ns == ls && t < 60*TPS)
            shadow_learn_wrap((ls*2+1) % 16, t);
        shadow_round_filter();
        if (shadow_check()) shadow_offsets();
    endfunction

    // Apply one command to the shadow table and return the readback it must produce
    function automatic readback_t predict_readback(logic [1:0] op, logic [7:0] nb,
                                                   logic [7:0] lb, logic [15:0] t,
                                                   logic [7:0] q);
        readback_t rb;
        if (op == OP_OBSERVE)
            shadow_observe(nb, lb, t);
        else if (op == OP_CLEAR)
        begin
            foreach (shadow_interval[i]) shadow_interval[i] = 16'd0;
            foreach (shadow_adjust[i]) shadow_adjust[i] = 16'd0;
        end
        rb.entry_ticks  = shadow_interval[q[6:4]*2 + q[0]];
        rb.slot_adjust  = shadow_adjust[q[6:4]];
        rb.table_valid  = shadow_valid | shadow_frozen;
        rb.table_frozen = shadow_frozen;
        return rb;
    endfunction

    // Hold the transaction until accepted; idle first at the current rate
    task automatic send_cmd(logic [1:0] op, logic [7:0] nb, logic [7:0] lb,
                            logic [15:0] t, logic [7:0] q, bit has_fixed,
                            readback_t fixed);
        readback_t rb;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, q, t, lb, nb, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        rb = predict_readback(op, nb, lb, t, q);
        if (has_fixed && rb != fixed)
        begin
            $error("directed row disagrees with prediction: expected %h, predicted %h",
                   fixed, rb);
            mismatch_count++;
        end
        pending_readbacks.push_back(has_fixed ? fixed : rb);
    endtask

    // Receiver: random stalls, compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        readback_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[33:0];
                if (pending_readbacks.size() == 0)
                begin
                    $error("unexpected result %h", got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readbacks.pop_front();
                    if (got.entry_ticks !== want.entry_ticks)
                    begin
                        $error("entry_ticks: expected %0d, actual %0d",
                               want.entry_ticks, got.entry_ticks);
                        mismatch_count++;
                    end
                    if (got.slot_adjust !== want.slot_adjust)
                    begin
                        $error("slot_adjust: expected %0d, actual %0d",
                               $signed(want.slot_adjust), $signed(got.slot_adjust));
                        mismatch_count++;
                    end
                    if (got.table_valid !== want.table_valid)
                    begin
                        $error("table_valid: expected %0d, actual %0d",
                               want.table_valid, got.table_valid);
                        mismatch_count++;
                    end
                    if (got.table_frozen !== want.table_frozen)
                    begin
                        $error("table_frozen: expected %0d, actual %0d",
                               want.table_frozen, got.table_frozen);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Observe of a well-formed slot sequence: first then repeat, with plausible spacing
    task automatic send_sequence_pass(int jitter);
        logic [15:0] first_t, rep_t;
        for (int s = 0; s < 8; s++)
        begin
            rep_t   = 16'($urandom_range(8*TPS, 25*TPS));
            first_t = 16'(300*TPS + $urandom_range(0, 2*jitter) - jitter);
            send_cmd(OP_OBSERVE, {4'(s), 4'd1}, {4'(s), 4'd0}, rep_t,
                     8'($urandom_range(255)), 0, '0);
            send_cmd(OP_OBSERVE, {4'((s+1)%8), 4'd0}, {4'(s), 4'd1}, first_t - rep_t,
                     8'($urandom_range(255)), 0, '0);
            send_cmd(OP_OBSERVE, {4'((s+1)%8), 4'd0}, {4'(s), 4'd0}, first_t,
                     8'($urandom_range(255)), 0, '0);
        end
    endtask

    task automatic send_noise();
        logic [1:0] op;
        int pick;
        pick = $urandom_range(99);
        op = (pick < 70) ? OP_OBSERVE : (pick < 85) ? OP_QUERY : (pick < 95) ? 2'd3 : OP_CLEAR;
        send_cmd(op, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 0, '0);
    endtask

    // Drop tvalid and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readbacks.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    row_t directed [$];
    int   drain_limit;

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (shadow_interval[i]) shadow_interval[i] = 16'd0;
        foreach (shadow_adjust[i]) shadow_adjust[i] = 16'd0;
        shadow_frozen = 1'b0;
        shadow_valid  = 1'b0;

        // Directed rows: extremes, each opcode, ignored and special observes
        directed = '{
            '{OP_QUERY,   8'h00, 8'h00, 16'h0000, 8'h00, 1, '0},
            '{OP_QUERY,   8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1, '0},
            '{2'd3,       8'hAA, 8'h55, 16'h5555, 8'h8E, 1, '0},
            '{OP_OBSERVE, 8'h10, 8'h72, 16'd2400,  8'h00, 1, '0},
            '{OP_OBSERVE, 8'h10, 8'h00, 16'd2400,  8'h00, 0, '0},
            '{OP_OBSERVE, 8'h10, 8'h00, 16'd1441,  8'h00, 0, '0},
            '{OP_OBSERVE, 8'h10, 8'h00, 16'd3839,  8'h00, 0, '0},
            '{OP_OBSERVE, 8'h10, 8'h00, 16'd3840,  8'h00, 0, '0},
            '{OP_OBSERVE, 8'h00, 8'h01, 16'd100,   8'h01, 0, '0},
            '{OP_OBSERVE, 8'h01, 8'h00, 16'd479,   8'h01, 0, '0},
            '{OP_OBSERVE, 8'h00, 8'h00, 16'd480,   8'h01, 0, '0},
            '{OP_OBSERVE, 8'h11, 8'h00, 16'd2500,  8'h11, 0, '0},
            '{OP_OBSERVE, 8'h11, 8'h01, 16'd2500,  8'h11, 0, '0},
            '{OP_OBSERVE, 8'h00, 8'h71, 16'd2400,  8'hF0, 0, '0},
            '{OP_OBSERVE, 8'h80, 8'h70, 16'd2400,  8'h70, 0, '0},
            '{OP_OBSERVE, 8'hF1, 8'h70, 16'd150,   8'h71, 0, '0},
            '{OP_OBSERVE, 8'h55, 8'h44, 16'hFFFF,  8'h4E, 0, '0},
            '{OP_CLEAR,   8'h00, 8'h00, 16'h0000, 8'h71, 0, '0},
            '{OP_QUERY,   8'h00, 8'h00, 16'h0000, 8'h70, 0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_cmd(directed[i].opcode, directed[i].new_seq, directed[i].last_seq,
                     directed[i].ticks, directed[i].query_seq, directed[i].has_fixed,
                     directed[i].fixed);

        // Pause until everything has drained at least once
        drain();

        // Random phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 76) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 76) : 0;
            for (int k = 0; k < 20; k++)
            begin
                if ($urandom_range(99) < 75)
                    send_sequence_pass((k % 3 == 0) ? 0 : $urandom_range(4*TPS));
                else
                    repeat (10) send_noise();
                if ($urandom_range(9) == 0)
                    send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom), 0, '0);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_axis_tvalid <= 1'b0;

        drain_limit = 0;
        while (pending_readbacks.size() != 0 && drain_limit < 100000)
        begin
            @(posedge clk);
            drain_limit++;
        end
        repeat (60) @(posedge clk);

        if (mismatch_count == 0 && pending_readbacks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/pilt_pkg.sv
sv/pilt_ram.sv
sv/packet_interval_learning_table_top.sv
tb/packet_interval_learning_table_top_tb.sv
